// ===== hw/rtl/flpl_pkg.sv =====
// ----------------------------------------------------------------------------
// flpl_pkg: shared types and constants of the FLAC picture length finder
// Holds the byte patterns, status codes and the result record that the
// parser hands to the top level.
// ----------------------------------------------------------------------------
package flpl_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 24;
  localparam int unsigned StatW = 3;

  localparam logic [StatW-1:0] ST_FOUND       = 3'd0;
  localparam logic [StatW-1:0] ST_NO_MARKER   = 3'd1;
  localparam logic [StatW-1:0] ST_NO_PICTURE  = 3'd2;
  localparam logic [StatW-1:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [StatW-1:0] ST_TRUNCATED   = 3'd4;

  // Skip counts in bytes.
  localparam logic [LenW-1:0] SKIP_STREAMINFO = 24'd38;
  localparam logic [LenW-1:0] SKIP_PIC_HEAD   = 24'd14;
  localparam logic [LenW-1:0] SKIP_JPEG_REST  = 24'd20;
  localparam logic [LenW-1:0] SKIP_PNG_REST   = 24'd19;

  localparam logic [6:0] BLOCK_TYPE_PICTURE = 7'd6;

  // "fLaC", "jpeg" and "png" (last entry of png unused).
  localparam logic [3:0][ByteW-1:0] MARKER_CHARS = {8'h43, 8'h61, 8'h4C, 8'h66};
  localparam logic [3:0][ByteW-1:0] JPEG_CHARS   = {8'h67, 8'h65, 8'h70, 8'h6A};
  localparam logic [3:0][ByteW-1:0] PNG_CHARS    = {8'h00, 8'h67, 8'h6E, 8'h70};

  typedef struct packed {
    logic             emit;
    logic [StatW-1:0] status;
    logic [LenW-1:0]  length;
  } result_t;

endpackage

// ===== hw/rtl/flpl_if.sv =====
// ----------------------------------------------------------------------------
// flpl_if: valid/ready channels of the FLAC picture length finder
// One channel for file bytes and one for the result beats.
// ----------------------------------------------------------------------------
interface flpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, output data_byte, output start_of_file,
                  output end_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file,
                input end_of_file, output ready);
endinterface

interface flpl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] picture_length;

  modport source (output valid, output status, output picture_length, input ready);
  modport sink (input valid, input status, input picture_length, output ready);
endinterface

// ===== hw/rtl/flpl_parser.sv =====
// ----------------------------------------------------------------------------
// flpl_parser: per-byte parse state of the FLAC picture length finder
// Holds the phase, skip counter and field registers, and works out the next
// state and an optional result for the byte that is presented on adv.
// ----------------------------------------------------------------------------
module flpl_parser
  import flpl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [ByteW-1:0] data_byte,
  input  logic             sof,
  input  logic             eof,
  output result_t          res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_MARKER, PH_SKIP_HDR, PH_HEADER,
    PH_SKIP_MIME, PH_MIME, PH_SKIP_SIZE, PH_SIZE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LenW-1:0]  skip_r, skip_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [ByteW-1:0] btype_r, btype_nxt;
  logic [LenW-1:0]  acc_r, acc_nxt;
  logic [1:0]       flags_r, flags_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    idx_nxt    = idx_r;
    btype_nxt  = btype_r;
    acc_nxt    = acc_r;
    flags_nxt  = flags_r;
    res.emit   = 1'b0;
    res.status = ST_FOUND;
    res.length = '0;

    if (sof) begin
      skip_nxt  = '0;
      btype_nxt = '0;
      phase_nxt = PH_MARKER;
      idx_nxt   = '0;
      acc_nxt   = '0;
      flags_nxt = 2'b11;
    end

    unique case (phase_nxt)
      PH_MARKER: begin
        if (data_byte != MARKER_CHARS[idx_nxt]) flags_nxt[0] = 1'b0;
        if (idx_nxt == 2'd3) begin
          if (flags_nxt[0]) begin
            phase_nxt = PH_SKIP_HDR;
            skip_nxt  = SKIP_STREAMINFO;
          end else begin
            res.emit   = 1'b1;
            res.status = ST_NO_MARKER;
            phase_nxt  = PH_IDLE;
          end
        end else begin
          idx_nxt = idx_nxt + 2'd1;
        end
      end
      PH_SKIP_HDR, PH_SKIP_MIME, PH_SKIP_SIZE: begin
        skip_nxt = skip_nxt - 24'd1;
        if (skip_nxt == '0) begin
          case (phase_nxt)
            PH_SKIP_HDR:  phase_nxt = PH_HEADER;
            PH_SKIP_MIME: phase_nxt = PH_MIME;
            default:      phase_nxt = PH_SIZE;
          endcase
          idx_nxt   = '0;
          acc_nxt   = '0;
          flags_nxt = 2'b11;
        end
      end
      PH_HEADER: begin
        if (idx_nxt == 2'd0) btype_nxt = data_byte;
        else acc_nxt = {acc_nxt[LenW-ByteW-1:0], data_byte};
        if (idx_nxt == 2'd3) begin
          if (btype_nxt[6:0] == BLOCK_TYPE_PICTURE) begin
            phase_nxt = PH_SKIP_MIME;
            skip_nxt  = SKIP_PIC_HEAD;
          end else if (btype_nxt[7]) begin
            res.emit   = 1'b1;
            res.status = ST_NO_PICTURE;
            phase_nxt  = PH_IDLE;
          end else if (acc_nxt == '0) begin
            // An empty block body: the next byte opens another header.
            phase_nxt = PH_HEADER;
            idx_nxt   = '0;
            acc_nxt   = '0;
            flags_nxt = 2'b11;
          end else begin
            phase_nxt = PH_SKIP_HDR;
            skip_nxt  = acc_nxt;
          end
        end else begin
          idx_nxt = idx_nxt + 2'd1;
        end
      end
      PH_MIME: begin
        if (data_byte != JPEG_CHARS[idx_nxt]) flags_nxt[0] = 1'b0;
        if (idx_nxt != 2'd3 && data_byte != PNG_CHARS[idx_nxt]) flags_nxt[1] = 1'b0;
        if (idx_nxt == 2'd3) begin
          if (flags_nxt[0]) begin
            phase_nxt = PH_SKIP_SIZE;
            skip_nxt  = SKIP_JPEG_REST;
          end else if (flags_nxt[1]) begin
            phase_nxt = PH_SKIP_SIZE;
            skip_nxt  = SKIP_PNG_REST;
          end else begin
            res.emit   = 1'b1;
            res.status = ST_UNSUPPORTED;
            phase_nxt  = PH_IDLE;
          end
        end else begin
          idx_nxt = idx_nxt + 2'd1;
        end
      end
      PH_SIZE: begin
        acc_nxt = {acc_nxt[LenW-ByteW-1:0], data_byte};
        if (idx_nxt == 2'd3) begin
          res.emit   = 1'b1;
          res.status = ST_FOUND;
          res.length = acc_nxt;
          phase_nxt  = PH_IDLE;
        end else begin
          idx_nxt = idx_nxt + 2'd1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // The last byte of a file closes any parse that is still undecided.
    if (eof) begin
      if (!res.emit && phase_nxt != PH_IDLE) begin
        res.emit   = 1'b1;
        res.status = ST_TRUNCATED;
        res.length = '0;
      end
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      skip_r  <= '0;
      idx_r   <= '0;
      btype_r <= '0;
      acc_r   <= '0;
      flags_r <= 2'b11;
    end else if (adv) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      idx_r   <= idx_nxt;
      btype_r <= btype_nxt;
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.emit |=> phase_r == PH_IDLE)
    else $error("parser did not go idle after a result");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP_HDR || phase_r == PH_SKIP_MIME || phase_r == PH_SKIP_SIZE)
    |-> skip_r != '0)
    else $error("skip phase with an empty skip count");

  a_field_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |=> (idx_r == $past(idx_r)) || $past(adv && sof))
    else $error("field index moved while idle");

endmodule

// ===== hw/rtl/flac_picture_length_finder_top.sv =====
// ----------------------------------------------------------------------------
// flac_picture_length_finder_top: length of the first picture in a FLAC file
// Byte-stream parser that reports at most one status beat per file.
// ----------------------------------------------------------------------------
// The block takes one file byte per beat and accepts a byte every cycle while
// the result side keeps up. Each byte is held in the input register and is
// then folded into the parse state; the result beat that a deciding byte
// causes is offered in the cycle after that byte is folded in. The input
// register only moves forward when the result register is empty or being
// drained, so a result beat that is held off stalls the byte stream. At most
// one result beat (status and picture length) is produced per file; bytes
// after it are dropped until the next start-of-file byte.
module flac_picture_length_finder_top
  import flpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  flpl_in_if.sink     in_ch,
  flpl_out_if.source  out_ch
);

  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_sof_r;
  logic             in_eof_r;
  logic             out_valid_r;
  logic [StatW-1:0] out_status_r;
  logic [LenW-1:0]  out_len_r;
  logic             out_free;
  logic             adv;
  result_t          res;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_sof_r  <= in_ch.start_of_file;
      in_eof_r  <= in_ch.end_of_file;
    end
  end

  flpl_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .data_byte (in_byte_r),
    .sof       (in_sof_r),
    .eof       (in_eof_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      out_status_r <= res.status;
      out_len_r    <= res.length;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.picture_length = out_len_r;

  a_len_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_FOUND |-> out_len_r == '0)
    else $error("picture length set on a non-found result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !adv)
    else $error("parser advanced over a held result beat");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= ST_TRUNCATED)
    else $error("result status out of range");

  a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_free |=> !in_valid_r || $past(in_ch.valid))
    else $error("input register held a byte that was already parsed");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the FLAC picture length finder
// Feeds byte streams that are mostly well-formed files with random content,
// plus stray bytes, broken markers, truncations and abandoned files. A
// byte-level parser in the bench predicts each status beat. Results are
// compared field by field with the oldest prediction as they come out.
// ----------------------------------------------------------------------------
module tb;
  import flpl_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [3:0] {
    P_IDLE, P_MAGIC, P_SKIP_BODY, P_HEADER, P_SKIP_PIC, P_MIME, P_SKIP_FIELDS, P_SIZE
  } parse_phase_e;

  logic clk;
  logic rst_n;

  flpl_in_if  in_ch ();
  flpl_out_if out_ch ();

  flac_picture_length_finder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Parser state of the bench's own copy of the block.
  parse_phase_e phase      = P_IDLE;
  logic [23:0]  skip_cnt   = '0;
  logic [1:0]   field_idx  = '0;
  logic [7:0]   type_byte  = '0;
  logic [23:0]  len_acc    = '0;
  logic [1:0]   match_bits = 2'b11;

  result_t    expected_results[$];
  logic [7:0] file_bytes[$];
  int         errors            = 0;
  int         sent_bytes        = 0;
  int         cycle_count       = 0;
  int         send_odds         = 0;
  int         rx_odds           = 0;
  int         hold_req          = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void start_field(parse_phase_e next);
    phase      = next;
    field_idx  = '0;
    len_acc    = '0;
    match_bits = 2'b11;
  endfunction

  function automatic void start_skip(parse_phase_e skip_ph, logic [23:0] count,
                                     parse_phase_e after);
    if (count == '0) begin
      start_field(after);
    end else begin
      phase    = skip_ph;
      skip_cnt = count;
    end
  endfunction

  function automatic result_t finish_file(logic [2:0] status, logic [23:0] length);
    result_t r;
    r.emit   = 1'b1;
    r.status = status;
    r.length = length;
    phase    = P_IDLE;
    return r;
  endfunction

  // Folds one accepted byte into the parse state; returns the status beat it
  // causes, if any, with emit set.
  function automatic result_t parse_byte(logic [7:0] b, logic sof, logic eof);
    result_t    r;
    logic [1:0] i;
    r = '0;
    if (sof) begin
      skip_cnt  = '0;
      type_byte = '0;
      start_field(P_MAGIC);
    end
    i = field_idx;
    case (phase)
      P_MAGIC: begin
        if (b != MARKER_CHARS[i]) match_bits[0] = 1'b0;
        if (i == 2'd3) begin
          if (match_bits[0]) start_skip(P_SKIP_BODY, SKIP_STREAMINFO, P_HEADER);
          else r = finish_file(ST_NO_MARKER, '0);
        end else begin
          field_idx = i + 2'd1;
        end
      end
      P_SKIP_BODY, P_SKIP_PIC, P_SKIP_FIELDS: begin
        skip_cnt = skip_cnt - 24'd1;
        if (skip_cnt == '0) begin
          if (phase == P_SKIP_BODY) start_field(P_HEADER);
          else if (phase == P_SKIP_PIC) start_field(P_MIME);
          else start_field(P_SIZE);
        end
      end
      P_HEADER: begin
        if (i == 2'd0) type_byte = b;
        else len_acc = {len_acc[15:0], b};
        if (i == 2'd3) begin
          if (type_byte[6:0] == BLOCK_TYPE_PICTURE)
            start_skip(P_SKIP_PIC, SKIP_PIC_HEAD, P_MIME);
          else if (type_byte[7])
            r = finish_file(ST_NO_PICTURE, '0);
          else
            start_skip(P_SKIP_BODY, len_acc, P_HEADER);
        end else begin
          field_idx = i + 2'd1;
        end
      end
      P_MIME: begin
        if (b != JPEG_CHARS[i]) match_bits[0] = 1'b0;
        if (i != 2'd3 && b != PNG_CHARS[i]) match_bits[1] = 1'b0;
        if (i == 2'd3) begin
          if (match_bits[0]) start_skip(P_SKIP_FIELDS, SKIP_JPEG_REST, P_SIZE);
          else if (match_bits[1]) start_skip(P_SKIP_FIELDS, SKIP_PNG_REST, P_SIZE);
          else r = finish_file(ST_UNSUPPORTED, '0);
        end else begin
          field_idx = i + 2'd1;
        end
      end
      P_SIZE: begin
        len_acc = {len_acc[15:0], b};
        if (i == 2'd3) r = finish_file(ST_FOUND, len_acc);
        else field_idx = i + 2'd1;
      end
      default: begin
        phase = P_IDLE;
      end
    endcase
    // A decision on the final byte wins over truncation.
    if (eof) begin
      if (!r.emit && phase != P_IDLE) r = finish_file(ST_TRUNCATED, '0);
      phase = P_IDLE;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Sends one byte beat, with an optional idle burst ahead of it, and records
  // what the block should answer.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
    result_t r;
    if (send_odds != 0 && $urandom_range(0, send_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.start_of_file <= sof;
    in_ch.end_of_file   <= eof;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
    r = parse_byte(b, sof, eof);
    if (r.emit) begin
      expected_results.push_back(r);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  // Builds a file: marker, stream info, a few other blocks and a picture block.
  // Some files carry a broken marker, a last-flagged block, an odd MIME type
  // or a huge block body that the file ends inside.
  task automatic build_file();
    int          kind;
    int          nskip;
    logic [7:0]  t;
    logic [23:0] len;
    file_bytes.delete();
    for (int k = 0; k < 4; k++) file_bytes.push_back(MARKER_CHARS[k]);
    if ($urandom_range(0, 9) == 0) file_bytes[$urandom_range(0, 3)] = 8'($urandom);
    push_random(38);
    repeat ($urandom_range(0, 3)) begin
      t = {($urandom_range(0, 9) == 0), 7'($urandom_range(0, 127))};
      if (t[6:0] == BLOCK_TYPE_PICTURE) t[6:0] = 7'd127;
      len = 24'($urandom_range(0, 6));
      if ($urandom_range(0, 15) == 0) len = 24'($urandom);
      file_bytes.push_back(t);
      file_bytes.push_back(len[23:16]);
      file_bytes.push_back(len[15:8]);
      file_bytes.push_back(len[7:0]);
      if (t[7] || len > 24'd6) begin
        push_random($urandom_range(0, 4));
        return;
      end
      push_random(int'(len));
    end
    file_bytes.push_back({($urandom_range(0, 1) == 1), BLOCK_TYPE_PICTURE});
    push_random(3 + 14);
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      if (kind <= 2 || kind == 6) file_bytes.push_back(JPEG_CHARS[k]);
      else if (kind <= 7 && k < 3) file_bytes.push_back(PNG_CHARS[k]);
      else file_bytes.push_back(8'($urandom));
    end
    if (kind == 6 || kind == 7)
      file_bytes[file_bytes.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
    nskip = (kind <= 2) ? 20 : (kind <= 5) ? 19 : $urandom_range(19, 20);
    push_random(nskip);
    case ($urandom_range(0, 5))
      0: repeat (4) file_bytes.push_back(8'h00);
      1: repeat (4) file_bytes.push_back(8'hFF);
      default: push_random(4);
    endcase
    push_random($urandom_range(0, 3));
  endtask

  task automatic send_file(input int last, input bit with_eof);
    for (int k = 0; k <= last; k++)
      send_byte(file_bytes[k], k == 0, with_eof && k == last);
  endtask

  task automatic test_stray_bytes_and_markers();
    send_odds = 3;
    rx_odds   = 4;
    // Nothing has started yet, so these are dropped.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // Start and end on one byte.
    send_byte(8'h66, 1'b1, 1'b1);
    send_byte(8'h66, 1'b1, 1'b0);
    send_byte(8'h4C, 1'b0, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // Idle after the result: an end flag alone must not answer.
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b0);
    // A new start abandons the first attempt; the matching marker then ends.
    send_byte(8'h66, 1'b1, 1'b0);
    send_byte(8'h4C, 1'b0, 1'b0);
    send_byte(8'h66, 1'b1, 1'b0);
    send_byte(8'h4C, 1'b0, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'h43, 1'b0, 1'b1);
    // The marker decision falls on the final byte itself.
    send_byte(8'h66, 1'b1, 1'b0);
    send_byte(8'h4C, 1'b0, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_result_backpressure();
    send_odds = 0;
    rx_odds   = 0;
    hold_req  = 400;
    repeat (8) begin
      send_byte(8'h66, 1'b1, 1'b0);
      send_byte(8'h4C, 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(8'h43, 1'b0, 1'b0);
    end
    build_file();
    send_file(file_bytes.size() - 1, 1'b1);
  endtask

  task automatic test_random_files();
    int pick;
    int last;
    // The steady stream that follows brings the total to about 1300 bytes.
    while (sent_bytes < 900) begin
      send_odds = $urandom_range(0, 6);
      rx_odds   = $urandom_range(0, 12);
      pick      = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end else begin
        build_file();
        last = file_bytes.size() - 1;
        if (pick <= 3) last = $urandom_range(0, last);
        // The file without an end flag is cut off by the next start.
        send_file(last, pick != 1);
      end
    end
  endtask

  task automatic test_steady_stream();
    send_odds = 0;
    rx_odds   = 0;
    repeat (4) begin
      build_file();
      send_file(file_bytes.size() - 1, 1'b1);
    end
  endtask

  // Result side: random stall bursts, and a long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_req--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (rx_odds != 0 && $urandom_range(0, rx_odds) == 0) begin
        stall = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected: status %0d length %0h",
                                  out_ch.status, out_ch.picture_length));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.picture_length !== want.length)
          report_mismatch($sformatf("picture length %0h, expected %0h",
                                    out_ch.picture_length, want.length));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.start_of_file = 1'b0;
    in_ch.end_of_file   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_stray_bytes_and_markers();
    wait_drained();
    test_result_backpressure();
    wait_drained();
    test_random_files();
    wait_drained();
    test_steady_stream();
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
